>>> design/pws_pkg.sv
// shared constants, payload types and cosine table contents for the plane wave sum block
package pws_pkg;

	localparam int MAX_MODES       = 1024;
	localparam int COS_TABLE_DEPTH = 1024;
	localparam int CORDIC_STEPS    = 14;

	localparam int MODE_AW = $clog2(MAX_MODES);
	localparam int CNT_W   = $clog2(MAX_MODES + 1);
	localparam int COS_IW  = $clog2(COS_TABLE_DEPTH);
	localparam int ACC_W   = 50;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TILT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = CFG_IDX_W'(1);

	typedef struct packed {
		logic               command;
		logic        [9:0]  mode_index;
		logic signed [15:0] amplitude;
		logic signed [23:0] freq_x;
		logic signed [23:0] freq_y;
		logic        [15:0] phase;
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
	} pws_req_t;

	typedef struct packed {
		logic signed [31:0] field_value;
		logic               is_positive;
	} pws_rsp_t;

	typedef struct packed {
		logic signed [15:0] amplitude;
		logic signed [23:0] freq_x;
		logic signed [23:0] freq_y;
		logic        [15:0] phase;
	} mode_t;

	typedef logic signed [15:0] cos_rom_t [COS_TABLE_DEPTH];

	localparam int ATAN_TURNS [CORDIC_STEPS] = '{
		8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1
	};

	// cordic cosine of a 16-bit turn angle, signed q1.15
	function automatic logic signed [15:0] cos_turn(input logic [15:0] a);
		longint z;
		longint x;
		longint y;
		longint dx;
		longint dy;
		longint r;
		logic   flip;
		int     k;
		z    = longint'($signed(a));
		flip = 1'b0;
		x    = 652032874;
		y    = 0;
		if (z > 16384) begin
			z    = z - 32768;
			flip = 1'b1;
		end else if (z < -16384) begin
			z    = z + 32768;
			flip = 1'b1;
		end
		for (k = 0; k < CORDIC_STEPS; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(ATAN_TURNS[k]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(ATAN_TURNS[k]);
			end
		end
		r = (x + 16384) >>> 15;
		if (r > 32767) r = 32767;
		if (r < -32767) r = -32767;
		if (flip) r = -r;
		return 16'(r);
	endfunction

	// table entry i holds the cosine at the turn i * 65536 / depth
	function automatic cos_rom_t cos_rom_init();
		cos_rom_t rom;
		longint   t;
		int       i;
		for (i = 0; i < COS_TABLE_DEPTH; i++) begin
			t      = (longint'(i) * 65536) / COS_TABLE_DEPTH;
			rom[i] = cos_turn(16'(t));
		end
		return rom;
	endfunction

endpackage

>>> design/pws_req_if.sv
// request channel: load a mode or evaluate a point
interface pws_req_if;
	import pws_pkg::*;

	logic     valid;
	logic     ready;
	pws_req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> design/pws_rsp_if.sv
// response channel: field sum and its sign
interface pws_rsp_if;
	import pws_pkg::*;

	logic     valid;
	logic     ready;
	pws_rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> design/pws_cfg_if.sv
// configuration write channel: register index and data
interface pws_cfg_if;
	import pws_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/plane_wave_sum_sign.sv
// top level: plane wave mode table, per-point mode sum and sign flag
//
// A load beat writes one mode into the mode memory and gives no response.
// An evaluate beat walks the first active_modes entries (capped at the table size), reading
// one mode per cycle from the mode memory. Each mode is read through the single read
// port and then passes the pipeline stages (spatial products, angle and cosine lookup,
// amplitude product, accumulate). Once the walk is done and the pipe is seen empty, the
// block rounds, saturates and registers the response, and goes back to idle, where it
// takes the next beat. With no active modes an evaluate reads nothing and goes straight
// to rounding and registering the response. The response waits in an output register,
// and loads are taken while it waits; a following evaluate holds its result until that
// register is free. The mode memory has no reset: evaluating a mode that was never
// loaded gives an undefined value. Registers: index 0 is tilt (signed q8.16, added as
// tilt times x), index 1 is active_modes; other indexes are ignored.
module plane_wave_sum_sign (
	input  logic clk,
	input  logic arst_n,
	pws_req_if.sink   req,
	pws_rsp_if.source rsp,
	pws_cfg_if.sink   cfg
);
	import pws_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	localparam cos_rom_t COS_ROM = cos_rom_init();

	// configuration
	logic signed [23:0] tilt_q;
	logic        [10:0] active_q;

	// control
	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic             v_s1, v_s2, v_s3, v_s4;
	logic             out_valid_q;

	// datapath
	mode_t              mode_mem [MAX_MODES];
	mode_t              mode_s1;
	logic signed [23:0] px_q, py_q;
	logic signed [47:0] prod_x_s2, prod_y_s2;
	logic signed [15:0] amp_s2, amp_s3;
	logic        [15:0] phase_s2;
	logic signed [15:0] cos_s3;
	logic signed [31:0] term_s4;
	logic signed [ACC_W-1:0] acc_q;
	pws_rsp_t           out_q;

	logic req_fire;
	logic load_we;
	logic eval_start;
	logic issue;
	logic in_flight;
	logic finish_go;

	logic signed [48:0]      sum_s2;
	logic        [15:0]      angle_s2;
	logic signed [ACC_W:0]   rnd;
	logic signed [ACC_W-12:0] scaled;
	logic signed [31:0]      sat_value;

	assign req_fire   = req.valid && req.ready;
	assign load_we    = req_fire && (req.payload.command == CMD_LOAD)
		&& (32'(req.payload.mode_index) < MAX_MODES);
	assign eval_start = req_fire && (req.payload.command == CMD_EVAL);
	assign issue      = (state_q == ST_RUN) && (cnt_q != n_q);
	assign in_flight  = v_s1 || v_s2 || v_s3 || v_s4;
	assign finish_go  = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);

	assign req.ready   = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_q   <= '0;
			active_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_TILT:   tilt_q   <= $signed(cfg.data[23:0]);
				REG_ACTIVE: active_q <= cfg.data[10:0];
				default:    ;
			endcase
		end
	end

	// sequencer: issue one mode read per cycle, then drain the pipe and raise the response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			// a new response may replace the one taken in the same cycle
			if (finish_go) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (eval_start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
						if (32'(active_q) > MAX_MODES) n_q <= CNT_W'(MAX_MODES);
						else n_q <= CNT_W'(active_q);
					end
				end
				ST_RUN: begin
					if (issue) cnt_q <= cnt_q + CNT_W'(1);
					else if (!in_flight) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (finish_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// mode memory, one write port for loads and one registered read port for the walk
	always_ff @(posedge clk) begin
		if (load_we) begin
			mode_mem[MODE_AW'(req.payload.mode_index)] <= '{
				amplitude: req.payload.amplitude,
				freq_x:    req.payload.freq_x,
				freq_y:    req.payload.freq_y,
				phase:     req.payload.phase
			};
		end
		mode_s1 <= mode_mem[cnt_q[MODE_AW-1:0]];
	end

	// phase argument in turns: low 16 bits of the q.28 angle shifted down by 12, plus the mode phase
	assign sum_s2   = 49'(prod_x_s2) + 49'(prod_y_s2);
	assign angle_s2 = sum_s2[27:12] + phase_s2;

	// round half up to q16.16 and clamp to the 32-bit range
	assign rnd    = (ACC_W+1)'(acc_q) + (ACC_W+1)'(2048);
	assign scaled = rnd[ACC_W:12];
	always_comb begin
		if (scaled > (ACC_W-11)'(64'sd2147483647)) sat_value = 32'sh7fffffff;
		else if (scaled < -(ACC_W-11)'(64'sd2147483648)) sat_value = 32'sh80000000;
		else sat_value = scaled[31:0];
	end

	// mode pipeline and accumulator
	always_ff @(posedge clk) begin
		if (eval_start) begin
			px_q  <= req.payload.point_x;
			py_q  <= req.payload.point_y;
			acc_q <= ACC_W'(tilt_q * req.payload.point_x);
		end else if (v_s4) begin
			// doubled term, sign extended into the accumulator
			acc_q <= acc_q + ACC_W'($signed({term_s4, 1'b0}));
		end
		// stage 2: spatial products
		prod_x_s2 <= mode_s1.freq_x * px_q;
		prod_y_s2 <= mode_s1.freq_y * py_q;
		amp_s2    <= mode_s1.amplitude;
		phase_s2  <= mode_s1.phase;
		// stage 3: cosine lookup
		cos_s3 <= COS_ROM[angle_s2[15 -: COS_IW]];
		amp_s3 <= amp_s2;
		// stage 4: weighted term
		term_s4 <= amp_s3 * cos_s3;
		if (finish_go) begin
			out_q.field_value <= sat_value;
			out_q.is_positive <= (acc_q > 0);
		end
	end

	// the walk never overruns the mode count
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= n_q)
		else $error("mode counter beyond active count");

	// pipeline stages only carry modes while an evaluate is running
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2 || v_s3 || v_s4) |-> (state_q == ST_RUN))
		else $error("mode in flight outside run state");

	// a response only appears after the finish step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("response raised outside finish");

	// finish is reached only once the pipe has drained
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && (cnt_q == n_q) && in_flight |=> (state_q == ST_RUN))
		else $error("finish entered with modes in flight");

endmodule
